@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define SMX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define SMX_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/core/smx_pkg.sv @@
`default_nettype none
package smx_pkg;

  localparam int DEF_DATA_STACK_DEPTH = 64;
  localparam int DEF_CALL_STACK_DEPTH = 64;
  localparam int DEF_MEM_WORDS = 128;
  localparam int DEF_FRAME_DEPTH = 16;
  localparam int DEF_PROG_DEPTH = 1024;

  localparam int WORD_W = 32;
  localparam int CMD_W = 5;
  localparam int FAULT_W = 3;
  localparam int IN_W = 40;

  localparam logic [CMD_W-1:0] OP_PUSH  = 5'd0;
  localparam logic [CMD_W-1:0] OP_POP   = 5'd1;
  localparam logic [CMD_W-1:0] OP_DUP   = 5'd2;
  localparam logic [CMD_W-1:0] OP_ADD   = 5'd3;
  localparam logic [CMD_W-1:0] OP_SUB   = 5'd4;
  localparam logic [CMD_W-1:0] OP_MUL   = 5'd5;
  localparam logic [CMD_W-1:0] OP_DIV   = 5'd6;
  localparam logic [CMD_W-1:0] OP_JMP   = 5'd7;
  localparam logic [CMD_W-1:0] OP_JIT   = 5'd8;
  localparam logic [CMD_W-1:0] OP_JIF   = 5'd9;
  localparam logic [CMD_W-1:0] OP_CALL  = 5'd10;
  localparam logic [CMD_W-1:0] OP_RET   = 5'd11;
  localparam logic [CMD_W-1:0] OP_EQ    = 5'd14;
  localparam logic [CMD_W-1:0] OP_GT    = 5'd15;
  localparam logic [CMD_W-1:0] OP_GE    = 5'd16;
  localparam logic [CMD_W-1:0] OP_LT    = 5'd17;
  localparam logic [CMD_W-1:0] OP_LE    = 5'd18;
  localparam logic [CMD_W-1:0] OP_NE    = 5'd19;
  localparam logic [CMD_W-1:0] OP_STO   = 5'd20;
  localparam logic [CMD_W-1:0] OP_RCL   = 5'd21;
  localparam logic [CMD_W-1:0] OP_END   = 5'd22;
  localparam logic [CMD_W-1:0] OP_PRN   = 5'd23;
  localparam logic [CMD_W-1:0] OP_STL   = 5'd24;
  localparam logic [CMD_W-1:0] OP_RCE   = 5'd25;
  localparam logic [CMD_W-1:0] OP_ALC   = 5'd26;
  localparam logic [CMD_W-1:0] OP_FRE   = 5'd27;
  localparam logic [CMD_W-1:0] OP_ENTRY = 5'd29;
  localparam logic [CMD_W-1:0] OP_LEAVE = 5'd30;

  localparam logic [FAULT_W-1:0] FLT_NONE  = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_UNDER = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_OVER  = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_CALL  = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_DIV0  = 3'd4;
  localparam logic [FAULT_W-1:0] FLT_ADDR  = 3'd5;

endpackage
`default_nettype wire

@@ rtl/core/smx_ram.sv @@
`default_nettype none
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/core/smx_div.sv @@
`default_nettype none
module smx_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [smx_pkg::WORD_W-1:0]  dividend,
  input  wire logic [smx_pkg::WORD_W-1:0]  divisor,
  output logic                             done,
  output logic      [smx_pkg::WORD_W-1:0]  quotient
);
  import smx_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic              neg;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;

  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff = rem_sh - {1'b0, dvs};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/stack_machine_executor.sv @@
// An accepted word is registered while its operands are read from the stack
// memories, executes in the EXEC state and has its result word registered onto
// the output, or held pending while it stalls. Words are taken one at a time;
// CALL adds a state to save the frame base, DIV waits for the serial divider.
// Reset: synchronous; afterwards the call stack, data memory and frame table
// are zeroed, one entry a cycle, until the deepest of them is cleared.
`default_nettype none
`include "assert_macros.svh"
module stack_machine_executor #(
  parameter int DATA_STACK_DEPTH = smx_pkg::DEF_DATA_STACK_DEPTH,
  parameter int CALL_STACK_DEPTH = smx_pkg::DEF_CALL_STACK_DEPTH,
  parameter int MEM_WORDS = smx_pkg::DEF_MEM_WORDS,
  parameter int FRAME_DEPTH = smx_pkg::DEF_FRAME_DEPTH,
  parameter int PROG_DEPTH = smx_pkg::DEF_PROG_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // cmd[4:0], arg[36:5], zero fill
  input  wire logic [smx_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // next_ip, print_valid, print_value, halted, fault, zero fill
  output logic [((($clog2(PROG_DEPTH) + 37) + 7) / 8) * 8 - 1:0] m_tdata
);
  import smx_pkg::*;

  localparam int PW = $clog2(PROG_DEPTH);
  localparam int OW = (((PW + 37) + 7) / 8) * 8;
  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DTW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int CAW = $clog2(CALL_STACK_DEPTH);
  localparam int CTW = $clog2(CALL_STACK_DEPTH + 1);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int CLR_A = (CALL_STACK_DEPTH > MEM_WORDS) ? CALL_STACK_DEPTH : MEM_WORDS;
  localparam int CLR_LEN = (CLR_A > FRAME_DEPTH) ? CLR_A : FRAME_DEPTH;
  localparam int CLW = $clog2(CLR_LEN + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_CALL2 = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CLW-1:0]     clr_cnt;
  logic [CMD_W-1:0]   cmd_r;
  logic [WORD_W-1:0]  arg_r;
  logic               local_ok_r;
  logic [CAW-1:0]     local_idx_r;
  logic [PW-1:0]      pc;
  logic [PW-1:0]      pc_next;
  logic [DTW-1:0]     dtop;
  logic [DTW-1:0]     dtop_next;
  logic [CTW-1:0]     ctop;
  logic [CTW-1:0]     ctop_next;
  logic [WORD_W-1:0]  fbase;
  logic [WORD_W-1:0]  fbase_next;
  logic [FAW-1:0]     fidx;
  logic [FAW-1:0]     fidx_next;
  logic [DAW-1:0]     div_addr;
  logic [DAW-1:0]     div_addr_next;
  logic               pend_valid;
  logic [OW-1:0]      pend_word;

  logic [CMD_W-1:0]   in_cmd;
  logic [WORD_W-1:0]  in_arg;
  logic               accept;
  logic [33:0]        local_c;
  logic               local_ok_c;
  logic [DTW-1:0]     dtop_m1;
  logic [DTW-1:0]     dtop_m2;
  logic [CTW-1:0]     ctop_m1;
  logic [CTW-1:0]     ctop_m2;

  logic               ds_we;
  logic [DAW-1:0]     ds_waddr;
  logic [WORD_W-1:0]  ds_wdata;
  logic [WORD_W-1:0]  ds_rd_a;
  logic [WORD_W-1:0]  ds_rd_b;
  logic               cs_we;
  logic [CAW-1:0]     cs_waddr;
  logic [WORD_W-1:0]  cs_wdata;
  logic [CAW-1:0]     cs_raddr_a;
  logic [WORD_W-1:0]  cs_rd_a;
  logic [WORD_W-1:0]  cs_rd_b;
  logic               dm_we;
  logic [MAW-1:0]     dm_waddr;
  logic [WORD_W-1:0]  dm_wdata;
  logic [WORD_W-1:0]  dm_rd;
  logic               ft_we;
  logic [FAW-1:0]     ft_waddr;
  logic [WORD_W-1:0]  ft_wdata;

  logic               div_start;
  logic               div_done;
  logic [WORD_W-1:0]  div_q;

  logic [FAULT_W-1:0] flt;
  logic               pv;
  logic [WORD_W-1:0]  pval;
  logic               halt;
  logic [PW-1:0]      nip;
  logic [OW-1:0]      res_word;
  logic               slot_free;

  logic [WORD_W-1:0]  x;
  logic [WORD_W-1:0]  y;
  logic [WORD_W-1:0]  alu;
  logic               mem_ok;
  logic               tgt_ok;
  logic [PW:0]        pc_inc;
  logic [PW-1:0]      pc_after;
  logic [PW:0]        ret_inc;
  logic [PW-1:0]      ret_after;
  logic               ds_empty;
  logic               ds_lt2;
  logic               ds_full;
  logic [33:0]        alc_top;
  logic               taken;

  assign in_cmd = s_tdata[CMD_W-1:0];
  assign in_arg = s_tdata[CMD_W+WORD_W-1:CMD_W];
  assign s_tready = (state == S_IDLE) && !pend_valid;
  assign accept = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  assign local_c = {{2{in_arg[WORD_W-1]}}, in_arg} + {{2{fbase[WORD_W-1]}}, fbase} - 34'd1;
  assign local_ok_c = !local_c[33] && (local_c < 34'(CALL_STACK_DEPTH));
  assign dtop_m1 = dtop - DTW'(1);
  assign dtop_m2 = dtop - DTW'(2);
  assign ctop_m1 = ctop - CTW'(1);
  assign ctop_m2 = ctop - CTW'(2);
  assign cs_raddr_a = (in_cmd == OP_RCE) ? local_c[CAW-1:0] : ctop_m1[CAW-1:0];

  smx_ram #(.WIDTH(WORD_W), .DEPTH(DATA_STACK_DEPTH)) u_data_stack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr_a(dtop_m1[DAW-1:0]), .rdata_a(ds_rd_a),
    .raddr_b(dtop_m2[DAW-1:0]), .rdata_b(ds_rd_b)
  );

  smx_ram #(.WIDTH(WORD_W), .DEPTH(CALL_STACK_DEPTH)) u_call_stack (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr_a(cs_raddr_a), .rdata_a(cs_rd_a),
    .raddr_b(ctop_m2[CAW-1:0]), .rdata_b(cs_rd_b)
  );

  smx_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_data_mem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr_a(in_arg[MAW-1:0]), .rdata_a(dm_rd),
    .raddr_b(in_arg[MAW-1:0]), .rdata_b()
  );

  smx_ram #(.WIDTH(WORD_W), .DEPTH(FRAME_DEPTH)) u_frame_table (
    .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
    .raddr_a(fidx), .rdata_a(),
    .raddr_b(fidx), .rdata_b()
  );

  smx_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(x), .divisor(y), .done(div_done), .quotient(div_q)
  );

  assign x = ds_rd_a;
  assign y = ds_rd_b;
  assign mem_ok = !arg_r[WORD_W-1] && (arg_r < WORD_W'(MEM_WORDS));
  assign tgt_ok = !arg_r[WORD_W-1] && (arg_r < WORD_W'(PROG_DEPTH));
  assign pc_inc = {1'b0, pc} + (PW+1)'(1);
  assign pc_after = (pc_inc >= (PW+1)'(PROG_DEPTH)) ? '0 : pc_inc[PW-1:0];
  assign ret_inc = {1'b0, cs_rd_b[PW-1:0]} + (PW+1)'(1);
  assign ret_after = (ret_inc >= (PW+1)'(PROG_DEPTH)) ? '0 : ret_inc[PW-1:0];
  assign ds_empty = (dtop == '0);
  assign ds_lt2 = (dtop < DTW'(2));
  assign ds_full = (dtop >= DTW'(DATA_STACK_DEPTH));
  assign alc_top = 34'(ctop) + {{2{arg_r[WORD_W-1]}}, arg_r};
  assign taken = ((cmd_r == OP_JIT) == (x != '0));

  always_comb begin
    unique case (cmd_r)
      OP_ADD:  alu = x + y;
      OP_SUB:  alu = x - y;
      OP_MUL:  alu = x * y;
      OP_EQ:   alu = WORD_W'(x == y);
      OP_GT:   alu = WORD_W'($signed(x) < $signed(y));
      OP_GE:   alu = WORD_W'($signed(x) <= $signed(y));
      OP_LT:   alu = WORD_W'($signed(x) > $signed(y));
      OP_LE:   alu = WORD_W'($signed(x) >= $signed(y));
      default: alu = WORD_W'(x != y);
    endcase
  end

  always_comb begin
    state_next = state;
    flt = FLT_NONE;
    pv = 1'b0;
    pval = '0;
    halt = 1'b0;
    nip = pc_after;
    pc_next = pc;
    dtop_next = dtop;
    ctop_next = ctop;
    fbase_next = fbase;
    fidx_next = fidx;
    div_addr_next = div_addr;
    div_start = 1'b0;
    ds_we = 1'b0;
    ds_waddr = dtop[DAW-1:0];
    ds_wdata = x;
    cs_we = 1'b0;
    cs_waddr = ctop[CAW-1:0];
    cs_wdata = '0;
    dm_we = 1'b0;
    dm_waddr = arg_r[MAW-1:0];
    dm_wdata = x;
    ft_we = 1'b0;
    ft_waddr = fidx + FAW'(1);
    ft_wdata = arg_r + WORD_W'(fidx);
    unique case (state)
      S_CLEAR: begin
        cs_we = clr_cnt < CLW'(CALL_STACK_DEPTH);
        cs_waddr = clr_cnt[CAW-1:0];
        dm_we = clr_cnt < CLW'(MEM_WORDS);
        dm_waddr = clr_cnt[MAW-1:0];
        dm_wdata = '0;
        ft_we = clr_cnt < CLW'(FRAME_DEPTH);
        ft_waddr = clr_cnt[FAW-1:0];
        ft_wdata = '0;
        if (clr_cnt == CLW'(CLR_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (cmd_r)
          OP_PUSH, OP_RCL, OP_RCE: begin
            if (ds_full) begin
              flt = FLT_OVER;
            end else if (cmd_r == OP_RCL && !mem_ok) begin
              flt = FLT_ADDR;
            end else if (cmd_r == OP_RCE && !local_ok_r) begin
              flt = FLT_ADDR;
            end else begin
              ds_we = 1'b1;
              ds_wdata = (cmd_r == OP_PUSH) ? arg_r : ((cmd_r == OP_RCL) ? dm_rd : cs_rd_a);
              dtop_next = dtop + DTW'(1);
            end
          end
          OP_POP, OP_STO, OP_PRN, OP_STL: begin
            if (ds_empty) begin
              flt = FLT_UNDER;
            end else if (cmd_r == OP_STO && !mem_ok) begin
              flt = FLT_ADDR;
            end else if (cmd_r == OP_STL && !local_ok_r) begin
              flt = FLT_ADDR;
            end else begin
              dm_we = (cmd_r == OP_STO);
              cs_we = (cmd_r == OP_STL);
              cs_waddr = local_idx_r;
              cs_wdata = x;
              pv = (cmd_r == OP_PRN);
              pval = (cmd_r == OP_PRN) ? x : '0;
              dtop_next = dtop_m1;
            end
          end
          OP_DUP: begin
            if (ds_empty) begin
              flt = FLT_UNDER;
            end else if (ds_full) begin
              flt = FLT_OVER;
            end else begin
              ds_we = 1'b1;
              dtop_next = dtop + DTW'(1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
          OP_NE: begin
            if (ds_lt2) begin
              flt = FLT_UNDER;
            end else if (cmd_r == OP_DIV && y == '0) begin
              flt = FLT_DIV0;
            end else if (cmd_r == OP_DIV) begin
              div_start = 1'b1;
              div_addr_next = dtop_m2[DAW-1:0];
              dtop_next = dtop_m1;
              state_next = S_DIV;
            end else begin
              ds_we = 1'b1;
              ds_waddr = dtop_m2[DAW-1:0];
              ds_wdata = alu;
              dtop_next = dtop_m1;
            end
          end
          OP_JMP: begin
            if (!tgt_ok) begin
              flt = FLT_ADDR;
            end else begin
              nip = arg_r[PW-1:0];
            end
          end
          OP_JIT, OP_JIF: begin
            if (ds_empty) begin
              flt = FLT_UNDER;
            end else if (taken && !tgt_ok) begin
              flt = FLT_ADDR;
            end else begin
              if (taken) begin
                nip = arg_r[PW-1:0];
              end
              dtop_next = dtop_m1;
            end
          end
          OP_CALL: begin
            if (({1'b0, ctop} + (CTW+1)'(2)) > (CTW+1)'(CALL_STACK_DEPTH)) begin
              flt = FLT_CALL;
            end else if (!tgt_ok) begin
              flt = FLT_ADDR;
            end else begin
              cs_we = 1'b1;
              cs_wdata = WORD_W'(pc);
              nip = arg_r[PW-1:0];
              state_next = S_CALL2;
            end
          end
          OP_RET: begin
            if (ctop < CTW'(2)) begin
              flt = FLT_CALL;
            end else if (cs_rd_b >= WORD_W'(PROG_DEPTH)) begin
              flt = FLT_ADDR;
            end else begin
              fbase_next = cs_rd_a;
              ctop_next = ctop_m2;
              nip = ret_after;
            end
          end
          OP_END: begin
            halt = 1'b1;
            nip = pc;
          end
          OP_ALC: begin
            if (alc_top[33] || alc_top > 34'(CALL_STACK_DEPTH)) begin
              flt = FLT_CALL;
            end else begin
              ctop_next = alc_top[CTW-1:0];
            end
          end
          OP_FRE: begin
            if (arg_r[WORD_W-1] || arg_r > WORD_W'(ctop)) begin
              flt = FLT_CALL;
            end else begin
              ctop_next = ctop - arg_r[CTW-1:0];
            end
          end
          OP_ENTRY: begin
            if (({1'b0, fidx} + (FAW+1)'(1)) >= (FAW+1)'(FRAME_DEPTH)) begin
              flt = FLT_CALL;
            end else begin
              ft_we = 1'b1;
              fidx_next = fidx + FAW'(1);
            end
          end
          OP_LEAVE: begin
            if (fidx == '0) begin
              flt = FLT_CALL;
            end else begin
              fidx_next = fidx - FAW'(1);
            end
          end
          default: begin
          end
        endcase
        pc_next = nip;
      end
      S_CALL2: begin
        cs_we = 1'b1;
        cs_waddr = ctop[CAW-1:0] + CAW'(1);
        cs_wdata = fbase;
        ctop_next = ctop + CTW'(2);
        fbase_next = WORD_W'(ctop) + WORD_W'(2);
        state_next = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          ds_we = 1'b1;
          ds_waddr = div_addr;
          ds_wdata = div_q;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_word = OW'({flt, halt, pval, pv, nip});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pc <= '0;
      dtop <= '0;
      ctop <= '0;
      fbase <= '0;
      fidx <= '0;
      pend_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + CLW'(1);
      end
      pc <= pc_next;
      dtop <= dtop_next;
      ctop <= ctop_next;
      fbase <= fbase_next;
      fidx <= fidx_next;
      if (state == S_EXEC) begin
        if (slot_free) begin
          m_tvalid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end else if (pend_valid && slot_free) begin
        m_tvalid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      arg_r <= in_arg;
      local_ok_r <= local_ok_c;
      local_idx_r <= local_c[CAW-1:0];
    end
    div_addr <= div_addr_next;
    if (state == S_EXEC) begin
      if (slot_free) begin
        m_tdata <= res_word;
      end else begin
        pend_word <= res_word;
      end
    end else if (pend_valid && slot_free) begin
      m_tdata <= pend_word;
    end
  end

  `SMX_ASSERT(a_accept_exec, accept |=> state == S_EXEC, "accepted word did not execute")
  `SMX_NEVER(a_no_accept_pending, pend_valid && s_tready, "accept with a result pending")
  `SMX_NEVER(a_dtop_range, dtop > DTW'(DATA_STACK_DEPTH), "data stack top out of range")
  `SMX_NEVER(a_ctop_range, ctop > CTW'(CALL_STACK_DEPTH), "call stack top out of range")

endmodule
`default_nettype wire

@@ dv/stack_machine_executor_checker.sv @@
`timescale 1ns / 1ps
module stack_machine_executor_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  output int               fails,
  output int               pending,
  output int               results_seen,
  output int               faults_seen,
  output int               prints_seen
);
  import smx_pkg::*;

  localparam int DSD = 64;
  localparam int CSD = 64;
  localparam int MEMW = 128;
  localparam int FRD = 16;
  localparam int PRGD = 1024;

  typedef struct packed {
    logic [2:0]  fault;
    logic        halted;
    logic [31:0] print_value;
    logic        print_valid;
    logic [9:0]  next_ip;
  } exec_result_t;

  exec_result_t results_due[$];

  int          pc;
  logic [31:0] dstk [DSD];
  int          dtop;
  logic [31:0] cstk [CSD];
  int          ctop;
  logic [31:0] fbase;
  logic [31:0] dmem [MEMW];
  logic [31:0] ftab [FRD];
  int          findex;

  initial begin
    pc = 0; dtop = 0; ctop = 0; fbase = 0; findex = 0;
    for (int i = 0; i < CSD; i++) cstk[i] = 0;
    for (int i = 0; i < DSD; i++) dstk[i] = 0;
    for (int i = 0; i < MEMW; i++) dmem[i] = 0;
    for (int i = 0; i < FRD; i++) ftab[i] = 0;
    fails = 0; results_seen = 0; faults_seen = 0; prints_seen = 0;
  end

  function automatic int step_after(int a);
    return (a + 1 >= PRGD) ? 0 : a + 1;
  endfunction

  task automatic execute(input logic [4:0] cmd, input logic [31:0] arg,
                         output exec_result_t res);
    longint sarg, loc, nt;
    logic [31:0] x, y, r;
    int nxt;
    logic [2:0] flt;
    bit loc_ok;
    sarg = longint'($signed(arg));
    loc = sarg + longint'($signed(fbase)) - 1;
    loc_ok = loc >= 0 && loc < CSD;
    nxt = step_after(pc);
    flt = FLT_NONE;
    res = '0;
    case (cmd)
      OP_PUSH, OP_RCL, OP_RCE: begin
        if (dtop >= DSD) flt = FLT_OVER;
        else if (cmd == OP_RCL && (sarg < 0 || sarg >= MEMW)) flt = FLT_ADDR;
        else if (cmd == OP_RCE && !loc_ok) flt = FLT_ADDR;
        else begin
          r = (cmd == OP_PUSH) ? arg : (cmd == OP_RCL) ? dmem[int'(sarg)] : cstk[int'(loc)];
          dstk[dtop] = r;
          dtop++;
        end
      end
      OP_POP, OP_STO, OP_PRN, OP_STL: begin
        if (dtop < 1) flt = FLT_UNDER;
        else begin
          x = dstk[dtop-1];
          if (cmd == OP_STO && (sarg < 0 || sarg >= MEMW)) flt = FLT_ADDR;
          else if (cmd == OP_STL && !loc_ok) flt = FLT_ADDR;
          else begin
            if (cmd == OP_STO) dmem[int'(sarg)] = x;
            if (cmd == OP_STL) cstk[int'(loc)] = x;
            if (cmd == OP_PRN) begin
              res.print_valid = 1'b1;
              res.print_value = x;
            end
            dtop--;
          end
        end
      end
      OP_DUP: begin
        if (dtop < 1) flt = FLT_UNDER;
        else if (dtop >= DSD) flt = FLT_OVER;
        else begin
          dstk[dtop] = dstk[dtop-1];
          dtop++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
        if (dtop < 2) flt = FLT_UNDER;
        else begin
          x = dstk[dtop-1];
          y = dstk[dtop-2];
          if (cmd == OP_DIV && y == 0) flt = FLT_DIV0;
          else begin
            case (cmd)
              OP_ADD: r = x + y;
              OP_SUB: r = x - y;
              OP_MUL: r = x * y;
              OP_DIV: r = 32'(longint'($signed(x)) / longint'($signed(y)));
              OP_EQ:  r = {31'd0, x == y};
              OP_GT:  r = {31'd0, $signed(x) < $signed(y)};
              OP_GE:  r = {31'd0, $signed(x) <= $signed(y)};
              OP_LT:  r = {31'd0, $signed(x) > $signed(y)};
              OP_LE:  r = {31'd0, $signed(x) >= $signed(y)};
              default: r = {31'd0, x != y};
            endcase
            dstk[dtop-2] = r;
            dtop--;
          end
        end
      end
      OP_JMP: begin
        if (sarg < 0 || sarg >= PRGD) flt = FLT_ADDR;
        else nxt = int'(sarg);
      end
      OP_JIT, OP_JIF: begin
        if (dtop < 1) flt = FLT_UNDER;
        else begin
          x = dstk[dtop-1];
          if ((cmd == OP_JIT) == (x != 0)) begin
            if (sarg < 0 || sarg >= PRGD) flt = FLT_ADDR;
            else nxt = int'(sarg);
          end
          if (flt == FLT_NONE) dtop--;
        end
      end
      OP_CALL: begin
        if (ctop + 2 > CSD) flt = FLT_CALL;
        else if (sarg < 0 || sarg >= PRGD) flt = FLT_ADDR;
        else begin
          cstk[ctop] = pc;
          cstk[ctop+1] = fbase;
          ctop += 2;
          fbase = ctop;
          nxt = int'(sarg);
        end
      end
      OP_RET: begin
        if (ctop < 2) flt = FLT_CALL;
        else begin
          x = cstk[ctop-1];
          y = cstk[ctop-2];
          if (y >= PRGD) flt = FLT_ADDR;
          else begin
            fbase = x;
            ctop -= 2;
            nxt = step_after(int'(y));
          end
        end
      end
      OP_END: begin
        res.halted = 1'b1;
        nxt = pc;
      end
      OP_ALC: begin
        nt = longint'(ctop) + sarg;
        if (nt < 0 || nt > CSD) flt = FLT_CALL;
        else ctop = int'(nt);
      end
      OP_FRE: begin
        if (sarg < 0 || sarg > ctop) flt = FLT_CALL;
        else ctop -= int'(sarg);
      end
      OP_ENTRY: begin
        if (findex + 1 >= FRD) flt = FLT_CALL;
        else begin
          ftab[findex+1] = arg + findex;
          findex++;
        end
      end
      OP_LEAVE: begin
        if (findex == 0) flt = FLT_CALL;
        else findex--;
      end
      default: ;
    endcase
    pc = nxt;
    res.next_ip = nxt[9:0];
    res.fault = flt;
  endtask

  assign pending = results_due.size();

  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst && s_tvalid && s_tready) begin
      execute(s_tdata[4:0], s_tdata[36:5], want);
      results_due.push_back(want);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[46:0];
      results_seen++;
      if (got.fault != FLT_NONE) faults_seen++;
      if (got.print_valid) prints_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (got.next_ip !== want.next_ip) begin
          $display("%0t: next_ip expected %0d actual %0d", $time, want.next_ip, got.next_ip);
          fails++;
        end
        if (got.print_valid !== want.print_valid) begin
          $display("%0t: print_valid expected %0d actual %0d", $time,
                   want.print_valid, got.print_valid);
          fails++;
        end
        if (got.print_value !== want.print_value) begin
          $display("%0t: print_value expected %h actual %h", $time,
                   want.print_value, got.print_value);
          fails++;
        end
        if (got.halted !== want.halted) begin
          $display("%0t: halted expected %0d actual %0d", $time, want.halted, got.halted);
          fails++;
        end
        if (got.fault !== want.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, want.fault, got.fault);
          fails++;
        end
      end
    end
  end
endmodule

@@ dv/stack_machine_executor_test.sv @@
`timescale 1ns / 1ps
module stack_machine_executor_test;
  import smx_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // cmd, arg, zero fill
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // next_ip, print_valid, print_value, halted, fault, zero fill
  logic [47:0] m_tdata;
  int          fails, pending, results_seen, faults_seen, prints_seen;
  int          cycles;
  int          stall_left;
  bit          quiet;

  stack_machine_executor i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  stack_machine_executor_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .pending(pending), .results_seen(results_seen),
    .faults_seen(faults_seen), .prints_seen(prints_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  task automatic send(input logic [4:0] cmd, input logic [31:0] arg);
    int g;
    bit rdy;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'd0, arg, cmd};
    forever begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
      if (rdy) break;
    end
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 4))
      0, 1: return $urandom_range(0, 15);
      2: return 32'($signed($urandom_range(0, 144)) - 4);
      3: return $urandom_range(0, 1023);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: if (r < 45) return OP_PUSH;
      1: if (r < 40) return OP_CALL;
      2: if (r < 40) return (r < 25) ? OP_ENTRY : OP_LEAVE;
      default: if (r < 20) return OP_PUSH;
    endcase
    return 5'($urandom_range(0, 31));
  endfunction

  initial begin
    int mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_POP, 0);
    send(OP_PUSH, 32'h7fffffff);
    send(OP_PUSH, 32'h80000000);
    send(OP_ADD, 0);
    send(OP_PUSH, 32'hffffffff);
    send(OP_PUSH, 32'h80000000);
    send(OP_DIV, 0);
    send(OP_PUSH, 0);
    send(OP_PUSH, 5);
    send(OP_DIV, 0);
    send(OP_DUP, 0);
    send(OP_STO, 127);
    send(OP_RCL, 128);
    send(OP_JMP, 1023);
    send(OP_JMP, 1024);
    send(OP_CALL, 5);
    send(OP_STL, 0);
    send(OP_RCE, 32'hffffffff);
    send(OP_RET, 0);
    send(OP_RET, 0);
    send(OP_ALC, 64);
    send(OP_FRE, 32'hffffffff);
    send(OP_ENTRY, 32'h80000000);
    send(OP_LEAVE, 0);
    send(OP_LEAVE, 0);
    send(OP_PRN, 0);
    send(OP_END, 0);

    mode = 3;
    for (int i = 0; i < 1600; i++) begin
      if (i % 80 == 0) begin
        mode = $urandom_range(0, 4);
        quiet = ($urandom_range(0, 5) == 0);
      end
      if (i == 800) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send(rand_cmd(mode), rand_arg());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d instructions across push, call and frame biased phases.", results_seen);
    $display("Results with a fault: %0d, with a print: %0d.", faults_seen, prints_seen);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/smx_pkg.sv
rtl/core/smx_ram.sv
rtl/core/smx_div.sv
rtl/core/stack_machine_executor.sv
dv/stack_machine_executor_checker.sv
dv/stack_machine_executor_test.sv
